// File: design/ethernet_rx_deframer_32bit_macros.svh
// Assertion macros for the receive deframer.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef ETHERNET_RX_DEFRAMER_32BIT_MACROS_SVH
`define ETHERNET_RX_DEFRAMER_32BIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ERD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ERD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/erd_pkg.sv
// Shared types and helpers for the receive deframer.
// No dependencies.
package erd_pkg;

  typedef enum logic [2:0] {
    PH_DST_HI  = 3'd0,
    PH_DST_LO  = 3'd1,
    PH_SRC_LO  = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  // one bus cycle as seen by the block
  typedef struct packed {
    logic        in_valid;
    logic [31:0] data;
    logic [3:0]  keep;
    logic        last;
    logic        sink_ready;
  } beat_t;

  // word store: last in 36, keep in 35:32, data in 31:0
  typedef struct packed {
    logic        last;
    logic [3:0]  keep;
    logic [31:0] data;
  } word_t;

  typedef struct packed {
    phase_e phase;
    logic   held_valid;
  } core_stat_t;

  // byte swap so the first wire byte lands most significant
  function automatic logic [31:0] be_word(input logic [31:0] d);
    be_word = {d[7:0], d[15:8], d[23:16], d[31:24]};
  endfunction

endpackage

// File: design/erd_in_stage.sv
// Input register for the receive deframer.
// Depends on erd_pkg.
module erd_in_stage import erd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  output logic  item_ready_o,
  input  beat_t beat_i,
  output logic  beat_valid_o,
  input  logic  beat_pop_i,
  output beat_t beat_o
);

  logic  valid_q, valid_d;
  beat_t beat_q;

  // free slot, or the held beat moves on this cycle
  assign item_ready_o = !valid_q || beat_pop_i;
  assign valid_d      = item_valid_i || (valid_q && !beat_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i && item_ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

// File: design/erd_core.sv
// Header capture, two-byte realignment and result register.
// Depends on erd_pkg.
module erd_core import erd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_valid_i,
  input  beat_t       beat_i,
  output logic        beat_pop_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        emit_o,
  output word_t       word_o,
  output logic        sop_o,
  output logic        ovf_o,
  output logic [47:0] dest_o,
  output logic [47:0] src_o,
  output logic [15:0] type_o,
  output core_stat_t  stat_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] held_bytes_q, held_bytes_d;
  logic [1:0]  held_keep_q, held_keep_d;
  logic        held_last_q, held_last_d;
  logic        held_valid_q, held_valid_d;
  logic        fwp_q, fwp_d;
  logic [47:0] dest_q, dest_d;
  logic [47:0] src_q, src_d;
  logic [15:0] type_q, type_d;
  word_t       word_q, word_d;
  logic        emit_q, emit_d;
  logic        sop_q, sop_d;
  logic        ovf_q, ovf_d;
  logic        res_valid_q;

  logic        fire;
  logic        is_last;
  logic        emit_now;
  logic [31:0] w;

  assign fire       = beat_valid_i && (!res_valid_q || res_ready_i);
  assign beat_pop_o = fire;
  assign w          = be_word(beat_i.data);

  assign is_last  = (held_valid_q && held_last_q) ||
                    (beat_i.in_valid && beat_i.last && !beat_i.keep[2]);
  assign emit_now = (phase_q == PH_PAYLOAD) &&
                    ((held_valid_q && beat_i.in_valid) || is_last);

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_DST_LO:  if (beat_i.in_valid) phase_d = PH_SRC_LO;
      PH_SRC_LO:  if (beat_i.in_valid) phase_d = PH_TYPE;
      PH_TYPE:    if (beat_i.in_valid) phase_d = PH_PAYLOAD;
      PH_PAYLOAD: if (emit_now && is_last) phase_d = PH_DST_HI;
      default:    phase_d = beat_i.in_valid ? PH_DST_LO : PH_DST_HI;
    endcase
  end

  // header capture and payload datapath
  always_comb begin
    held_bytes_d = held_bytes_q;
    held_keep_d  = held_keep_q;
    held_last_d  = held_last_q;
    held_valid_d = held_valid_q;
    fwp_d        = fwp_q;
    dest_d       = dest_q;
    src_d        = src_q;
    type_d       = type_q;
    word_d       = word_q;
    emit_d       = 1'b0;
    sop_d        = 1'b0;
    ovf_d        = 1'b0;
    unique case (phase_q)
      PH_DST_LO: begin
        dest_d[15:0]  = w[31:16];
        src_d[47:32]  = w[15:0];
      end
      PH_SRC_LO: begin
        src_d[31:0] = w;
      end
      PH_TYPE: begin
        type_d       = w[31:16];
        held_bytes_d = beat_i.data[31:16];
        held_keep_d  = 2'b11;
        held_last_d  = 1'b0;
        held_valid_d = 1'b1;
        if (beat_i.in_valid) fwp_d = 1'b1;
      end
      PH_PAYLOAD: begin
        if (emit_now) begin
          emit_d       = 1'b1;
          word_d.data  = {beat_i.data[15:0], held_bytes_q};
          word_d.keep  = {(beat_i.in_valid ? beat_i.keep[1:0] : 2'b00), held_keep_q};
          word_d.last  = is_last;
          sop_d        = fwp_q;
          fwp_d        = 1'b0;
          ovf_d        = beat_i.in_valid && !beat_i.sink_ready;
          held_bytes_d = beat_i.data[31:16];
          held_keep_d  = beat_i.keep[3:2];
          held_last_d  = beat_i.last;
          held_valid_d = beat_i.in_valid && beat_i.keep[2];
        end
      end
      default: begin
        dest_d[47:16] = w;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DST_HI;
      held_bytes_q <= '0;
      held_keep_q  <= '0;
      held_last_q  <= 1'b0;
      held_valid_q <= 1'b0;
      fwp_q        <= 1'b0;
      dest_q       <= '0;
      src_q        <= '0;
      type_q       <= '0;
      word_q       <= '0;
      emit_q       <= 1'b0;
      sop_q        <= 1'b0;
      ovf_q        <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        phase_q      <= phase_d;
        held_bytes_q <= held_bytes_d;
        held_keep_q  <= held_keep_d;
        held_last_q  <= held_last_d;
        held_valid_q <= held_valid_d;
        fwp_q        <= fwp_d;
        dest_q       <= dest_d;
        src_q        <= src_d;
        type_q       <= type_d;
        word_q       <= word_d;
        emit_q       <= emit_d;
        sop_q        <= sop_d;
        ovf_q        <= ovf_d;
        res_valid_q  <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign emit_o      = emit_q;
  assign word_o      = word_q;
  assign sop_o       = sop_q;
  assign ovf_o       = ovf_q;
  assign dest_o      = dest_q;
  assign src_o       = src_q;
  assign type_o      = type_q;

  assign stat_o.phase      = phase_q;
  assign stat_o.held_valid = held_valid_q;

endmodule

// File: design/ethernet_rx_deframer_32bit.sv
// Ethernet receive deframer, 32-bit stream: top level.
// Depends on erd_pkg, erd_in_stage, erd_core and the assertion macro header.
//
// Usage:
//   Each item on the input channel (item_valid_i / item_ready_o) is one bus
//   cycle of the MAC stream: in_valid_i, in_data_i, in_keep_i, in_last_i and
//   sink_ready_i, whether or not the beat itself is valid.
//   Each item gives exactly one word on the result channel
//   (res_valid_o / res_ready_i): out_valid_o marks a payload word, with
//   out_data_o/out_keep_o/out_last_o, pkt_start_o and overflow_o;
//   dest_address_o, source_address_o and frame_type_o show the header
//   captured so far. When out_valid_o is low the word fields repeat the
//   last emitted word.
//   Path: an accepted item passes through the input register, then the
//   result register, which presents its result. Throughput: one item per
//   cycle while res_ready_i keeps the result channel draining.
//   Reset: all state clears, parser waits for the first header beat.
//   Stall: if res_ready_i is low the result is held, one more item is
//   taken into the input register, then item_ready_o drops.
`include "ethernet_rx_deframer_32bit_macros.svh"

module ethernet_rx_deframer_32bit import erd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  logic        in_valid_i,
  input  logic [31:0] in_data_i,
  input  logic [3:0]  in_keep_i,
  input  logic        in_last_i,
  input  logic        sink_ready_i,
  // result channel
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        out_valid_o,
  output logic [31:0] out_data_o,
  output logic [3:0]  out_keep_o,
  output logic        out_last_o,
  output logic        pkt_start_o,
  output logic        overflow_o,
  output logic [47:0] dest_address_o,
  output logic [47:0] source_address_o,
  output logic [15:0] frame_type_o
);

  beat_t      beat_in;
  beat_t      beat_reg;
  logic       beat_valid;
  logic       beat_pop;
  word_t      word;
  core_stat_t stat;

  assign beat_in.in_valid   = in_valid_i;
  assign beat_in.data       = in_data_i;
  assign beat_in.keep       = in_keep_i;
  assign beat_in.last       = in_last_i;
  assign beat_in.sink_ready = sink_ready_i;

  // stage 1: input register
  erd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_i),
    .item_ready_o (item_ready_o),
    .beat_i       (beat_in),
    .beat_valid_o (beat_valid),
    .beat_pop_i   (beat_pop),
    .beat_o       (beat_reg)
  );

  // stage 2: parse, realign, result register
  erd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat_reg),
    .beat_pop_o   (beat_pop),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .emit_o       (out_valid_o),
    .word_o       (word),
    .sop_o        (pkt_start_o),
    .ovf_o        (overflow_o),
    .dest_o       (dest_address_o),
    .src_o        (source_address_o),
    .type_o       (frame_type_o),
    .stat_o       (stat)
  );

  assign out_data_o = word.data;
  assign out_keep_o = word.keep;
  assign out_last_o = word.last;

  // flags only ride on an emitted payload word
  `ERD_ASSERT_SAME(a_sop_emit, pkt_start_o, out_valid_o, "sop without payload word")
  `ERD_ASSERT_SAME(a_ovf_emit, overflow_o, out_valid_o, "overflow without payload word")
  // empty result slot never blocks the input side
  `ERD_ASSERT_SAME(a_ready_free, !res_valid_o, item_ready_o, "input stalled with free output")
  // payload phase is held while no word goes out
  `ERD_ASSERT_NEXT(a_last_rst, beat_pop && stat.phase == PH_PAYLOAD && out_last_o == 1'b0
                   && u_core.emit_now == 1'b0, stat.phase == PH_PAYLOAD,
                   "payload phase left without an emitted word")

endmodule
